>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ATS_ASSERT_RUN(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ATS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ats_pkg.sv
// types, constants and character classes of the assembly token scanner
package ats_pkg;

	localparam int ATS_POS_BITS = 16;
	localparam int LEN_W        = 16;
	localparam int CHAR_W       = 8;
	localparam int RQ_DEPTH     = 4;

	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h27;
	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [LEN_W-1:0]  LEN_MAX      = 16'hFFFF;

	typedef enum logic [2:0] {
		K_EOF      = 3'd0,
		K_LABEL    = 3'd1,
		K_IDENT    = 3'd2,
		K_INT      = 3'd3,
		K_CHAR     = 3'd4,
		K_UNCLOSED = 3'd5,
		K_GARBAGE  = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE   = 3'd0,
		M_IDENT  = 3'd1,
		M_INT    = 3'd2,
		M_QOPEN  = 3'd3,
		M_QESC   = 3'd4,
		M_QCLOSE = 3'd5,
		M_HALT   = 3'd6
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic [CHAR_W-1:0] bad;
		logic              last;
	} result_t;

	// up to two results from one character, in delivery order
	typedef struct packed {
		logic    first_v;
		logic    second_v;
		result_t first;
		result_t second;
	} push_t;

	function automatic logic is_space(logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(logic [CHAR_W-1:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_digit(logic [CHAR_W-1:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_word(logic [CHAR_W-1:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
	endfunction

endpackage

>>> rtl/ats_scan.sv
// scan state registers and per-character token logic
module ats_scan import ats_pkg::*; #(
	parameter int POS_BITS = ATS_POS_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [CHAR_W-1:0] ch,
	output push_t             push
);

	mode_t                mode_q, mode_d;
	logic [POS_BITS-1:0]  pos_q, pos_d;
	logic [POS_BITS-1:0]  begin_q, begin_d;
	logic [LEN_W-1:0]     count_q, count_d;
	logic                 esc_q, esc_d;

	logic [POS_BITS-1:0]  pos_inc;
	logic [LEN_W-1:0]     count_inc;
	logic [LEN_W-1:0]     pos16;
	logic [LEN_W-1:0]     begin16;

	// path taken when the character is seen from idle
	logic                 idle_emit;
	result_t              idle_res;
	mode_t                idle_mode;
	logic [POS_BITS-1:0]  idle_begin;
	logic [LEN_W-1:0]     idle_count;
	logic                 idle_esc;

	logic                 use_idle;
	logic                 first_v;
	result_t              first_r;

	assign pos_inc   = pos_q + 1'b1;
	assign count_inc = (count_q == LEN_MAX) ? count_q : count_q + 1'b1;
	assign pos16     = LEN_W'(pos_q);
	assign begin16   = LEN_W'(begin_q);

	// token start from idle
	always_comb begin
		idle_emit  = 1'b0;
		idle_res   = '0;
		idle_mode  = M_IDLE;
		idle_begin = begin_q;
		idle_count = count_q;
		idle_esc   = esc_q;
		if (ch == CH_NUL) begin
			idle_emit       = 1'b1;
			idle_res.kind   = K_EOF;
			idle_res.start  = pos16;
			idle_count      = '0;
			idle_esc        = 1'b0;
		end else if (is_space(ch)) begin
			idle_mode = M_IDLE;
		end else if (is_alpha(ch) || ch == CH_UNDERSCORE) begin
			idle_mode  = M_IDENT;
			idle_begin = pos_q;
			idle_count = LEN_W'(1);
		end else if (is_digit(ch)) begin
			idle_mode  = M_INT;
			idle_begin = pos_q;
			idle_count = LEN_W'(1);
		end else if (ch == CH_QUOTE) begin
			idle_mode  = M_QOPEN;
			idle_begin = pos_inc;
			idle_count = '0;
			idle_esc   = 1'b0;
		end else begin
			idle_emit      = 1'b1;
			idle_res.kind  = K_GARBAGE;
			idle_res.start = pos16;
			idle_res.len   = LEN_W'(1);
			idle_res.bad   = ch;
			idle_mode      = M_HALT;
		end
	end

	// mode dispatch: close the open token, then maybe rescan from idle
	always_comb begin
		mode_d   = mode_q;
		begin_d  = begin_q;
		count_d  = count_q;
		esc_d    = esc_q;
		use_idle = 1'b0;
		first_v  = 1'b0;
		first_r  = '0;
		first_r.start = begin16;
		first_r.len   = count_q;
		unique case (mode_q)
			M_IDENT: begin
				if (ch != CH_NUL && is_word(ch)) begin
					count_d = count_inc;
				end else if (ch == CH_COLON) begin
					first_v      = 1'b1;
					first_r.kind = K_LABEL;
					mode_d       = M_IDLE;
				end else begin
					first_v      = 1'b1;
					first_r.kind = K_IDENT;
					use_idle     = 1'b1;
				end
			end
			M_INT: begin
				if (is_digit(ch)) begin
					count_d = count_inc;
				end else begin
					first_v      = 1'b1;
					first_r.kind = K_INT;
					use_idle     = 1'b1;
				end
			end
			M_QOPEN, M_QESC: begin
				if (ch == CH_NUL) begin
					first_v      = 1'b1;
					first_r.kind = K_UNCLOSED;
					use_idle     = 1'b1;
				end else begin
					count_d = count_inc;
					if (mode_q == M_QOPEN && ch == CH_BACKSLASH) begin
						esc_d  = 1'b1;
						mode_d = M_QESC;
					end else begin
						mode_d = M_QCLOSE;
					end
				end
			end
			M_QCLOSE: begin
				first_v = 1'b1;
				if (ch == CH_QUOTE) begin
					first_r.kind = K_CHAR;
					first_r.len  = esc_q ? LEN_W'(2) : LEN_W'(1);
					mode_d       = M_IDLE;
				end else begin
					first_r.kind = K_UNCLOSED;
					if (ch == CH_NUL) begin
						use_idle = 1'b1;
					end else begin
						mode_d = M_HALT;
					end
				end
			end
			M_HALT: begin
				use_idle = (ch == CH_NUL);
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase
		if (use_idle) begin
			mode_d  = idle_mode;
			begin_d = idle_begin;
			count_d = idle_count;
			esc_d   = idle_esc;
		end
		pos_d = (ch == CH_NUL) ? '0 : pos_inc;
	end

	// results handed to the queue
	always_comb begin
		push.first_v      = first_v;
		push.second_v     = use_idle && idle_emit;
		push.first        = first_r;
		push.first.last   = !(use_idle && idle_emit);
		push.second       = idle_res;
		push.second.last  = 1'b1;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			count_q <= '0;
			esc_q   <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			count_q <= count_d;
			esc_q   <= esc_d;
		end
	end

endmodule

>>> rtl/ats_resq.sv
// result queue: takes up to two results a cycle, delivers one per transfer
module ats_resq import ats_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_en,
	input  push_t   push,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	localparam int PTR_W = $clog2(RQ_DEPTH);
	localparam int CNT_W = $clog2(RQ_DEPTH + 1);

	result_t            mem_q [RQ_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_push;
	logic [PTR_W-1:0]   second_ptr;
	logic               pop;

	assign n_push     = push_en ? (CNT_W'(push.first_v) + CNT_W'(push.second_v)) : '0;
	assign second_ptr = push.first_v ? wr_ptr_q + 1'b1 : wr_ptr_q;
	assign pop        = out_valid && out_ready;
	assign out_valid  = (cnt_q != '0);
	assign space      = (cnt_q <= CNT_W'(RQ_DEPTH - 2));
	assign head       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push_en && push.first_v) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push_en && push.second_v) begin
			mem_q[second_ptr] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + n_push - CNT_W'(pop);
		end
	end

endmodule

>>> rtl/assembly_token_scanner_core.sv
// Streaming assembly token scanner, top level.
//
// Input channel: one ASCII character per transfer on ch (in_valid/in_ready).
// A NUL ends the text, gives an EOF result and restarts positions at zero.
// Output channel: one token per transfer (out_valid/out_ready) with kind,
// start, length, bad_char and last_of_run, which marks the final result
// caused by a character. A character gives zero, one or two results.
//
// Path: a taken character waits in the input register, is scanned there and
// its results go into the result queue. Throughput: one character per cycle
// while each character gives at most one result and the receiver takes
// every result; a character with two results holds the output for two
// transfers. The four-entry result queue and its fill count set this rate.
//
// Reset clears the scan mode, position and counts and empties the queue.
// When the receiver stalls, results wait in the queue; once fewer than two
// entries are free, in_ready drops until the receiver drains it.
module assembly_token_scanner_core import ats_pkg::*; #(
	parameter int POS_BITS = ATS_POS_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] ch,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        token_kind,
	output logic [LEN_W-1:0]  token_start,
	output logic [LEN_W-1:0]  token_length,
	output logic [CHAR_W-1:0] bad_char,
	output logic              last_of_run
);

	logic              valid_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              space;
	logic              fire;
	push_t             push;
	result_t           head;

	assign fire     = valid_s1 && space;
	assign in_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
		end
	end

	ats_scan #(
		.POS_BITS(POS_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch_s1),
		.push   (push)
	);

	ats_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (fire),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// result fields
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.len;
	assign bad_char     = head.bad;
	assign last_of_run  = head.last;

endmodule

>>> rtl/ats_checker.sv
// port-level checks of the token scanner, bound to the top level
`include "assert_macros.svh"

module ats_checker import ats_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        token_kind,
	input logic [LEN_W-1:0]  token_start,
	input logic [LEN_W-1:0]  token_length,
	input logic [CHAR_W-1:0] bad_char,
	input logic              last_of_run
);

	// no result is offered while reset is applied
	`ATS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result offered during reset")

	// a stalled result keeps its payload
	`ATS_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_start) && $stable(token_length), "stalled result changed")

	// the partner of a non-final result is already queued
	`ATS_ASSERT_RUN(a_pair_follows, out_valid && out_ready && !last_of_run |=> out_valid, "second result of a character missing")

	// an empty output side never blocks the input
	`ATS_ASSERT_RUN(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with nothing queued")

	// end of text closes a run with zero length
	`ATS_ASSERT_RUN(a_eof_shape, out_valid && token_kind == K_EOF |-> last_of_run && token_length == '0 && bad_char == '0, "malformed eof result")

endmodule

bind assembly_token_scanner_core ats_checker u_ats_checker (.*);

>>> verif/tb.sv
// self-checking testbench for the assembly token scanner core
module tb;
	import ats_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PER_PHASE = 225;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int SHOWN_FAULTS = 10;

	// tracks the scanner state and the tokens it still owes
	class token_ledger;
		result_t tokens_due[$];
		mode_t lex_mode;
		logic [LEN_W-1:0] at_pos;
		logic [LEN_W-1:0] tok_from;
		logic [LEN_W-1:0] tok_len;
		logic escaped;
		int faults;
		int matched;

		function new();
			lex_mode = M_IDLE;
			at_pos = '0;
			tok_from = '0;
			tok_len = '0;
			escaped = 1'b0;
			faults = 0;
			matched = 0;
		endfunction

		function bit blank_ch(logic [CHAR_W-1:0] c);
			return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function bit letter_ch(logic [CHAR_W-1:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function bit digit_ch(logic [CHAR_W-1:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void post(kind_t k, logic [LEN_W-1:0] s, logic [LEN_W-1:0] n,
				logic [CHAR_W-1:0] b);
			result_t r;
			r.kind = k;
			r.start = s;
			r.len = n;
			r.bad = b;
			r.last = 1'b0;
			tokens_due.push_back(r);
		endfunction

		function void grow();
			if (tok_len != LEN_MAX) tok_len++;
		endfunction

		// first character seen between tokens
		function void open_token(logic [CHAR_W-1:0] c, logic [LEN_W-1:0] p);
			lex_mode = M_IDLE;
			if (c == CH_NUL) begin
				post(K_EOF, p, '0, '0);
				tok_len = '0;
				escaped = 1'b0;
			end else if (blank_ch(c)) begin
				// whitespace between tokens is skipped
			end else if (letter_ch(c) || c == CH_UNDERSCORE) begin
				lex_mode = M_IDENT;
				tok_from = p;
				tok_len = LEN_W'(1);
			end else if (digit_ch(c)) begin
				lex_mode = M_INT;
				tok_from = p;
				tok_len = LEN_W'(1);
			end else if (c == CH_QUOTE) begin
				lex_mode = M_QOPEN;
				tok_from = p + 1'b1;
				tok_len = '0;
				escaped = 1'b0;
			end else begin
				post(K_GARBAGE, p, LEN_W'(1), c);
				lex_mode = M_HALT;
			end
		endfunction

		// advance on one accepted character
		function void take_char(logic [CHAR_W-1:0] c);
			int prior_n;
			logic [LEN_W-1:0] here;
			result_t r;
			prior_n = tokens_due.size();
			here = at_pos;
			case (lex_mode)
				M_IDENT: begin
					if (c != CH_NUL && (letter_ch(c) || digit_ch(c) || c == CH_UNDERSCORE)) begin
						grow();
					end else if (c == CH_COLON) begin
						post(K_LABEL, tok_from, tok_len, '0);
						lex_mode = M_IDLE;
					end else begin
						post(K_IDENT, tok_from, tok_len, '0);
						open_token(c, here);
					end
				end
				M_INT: begin
					if (digit_ch(c)) begin
						grow();
					end else begin
						post(K_INT, tok_from, tok_len, '0);
						open_token(c, here);
					end
				end
				M_QOPEN, M_QESC: begin
					if (c == CH_NUL) begin
						post(K_UNCLOSED, tok_from, tok_len, '0);
						open_token(c, here);
					end else begin
						grow();
						if (lex_mode == M_QOPEN && c == CH_BACKSLASH) begin
							escaped = 1'b1;
							lex_mode = M_QESC;
						end else begin
							lex_mode = M_QCLOSE;
						end
					end
				end
				M_QCLOSE: begin
					if (c == CH_QUOTE) begin
						post(K_CHAR, tok_from, escaped ? 16'd2 : 16'd1, '0);
						lex_mode = M_IDLE;
					end else begin
						post(K_UNCLOSED, tok_from, tok_len, '0);
						if (c == CH_NUL) open_token(c, here);
						else lex_mode = M_HALT;
					end
				end
				M_HALT: begin
					if (c == CH_NUL) open_token(c, here);
				end
				default: begin
					open_token(c, here);
				end
			endcase
			at_pos = (c == CH_NUL) ? '0 : here + 1'b1;
			// mark the final token of this character
			if (tokens_due.size() > prior_n) begin
				r = tokens_due.pop_back();
				r.last = 1'b1;
				tokens_due.push_back(r);
			end
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= SHOWN_FAULTS) $display("%s", msg);
		endfunction

		// compare one delivered token with the oldest one owed
		function void match_token(logic [2:0] kind, logic [LEN_W-1:0] start,
				logic [LEN_W-1:0] len, logic [CHAR_W-1:0] bad, logic last);
			result_t want;
			if (tokens_due.size() == 0) begin
				flag($sformatf("token %0d unexpected: kind %0d start %0d len %0d bad %h last %0b",
					matched, kind, start, len, bad, last));
			end else begin
				want = tokens_due.pop_front();
				if (want.kind !== kind || want.start !== start || want.len !== len ||
						want.bad !== bad || want.last !== last)
					flag($sformatf({"token %0d mismatch: expected kind %0d start %0d len %0d ",
						"bad %h last %0b, got kind %0d start %0d len %0d bad %h last %0b"},
						matched, want.kind, want.start, want.len, want.bad, want.last,
						kind, start, len, bad, last));
			end
			matched++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [CHAR_W-1:0] ch;
	logic out_valid;
	logic out_ready;
	logic [2:0] token_kind;
	logic [LEN_W-1:0] token_start;
	logic [LEN_W-1:0] token_length;
	logic [CHAR_W-1:0] bad_char;
	logic last_of_run;

	token_ledger ledger;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int cycle_cnt = 0;
	int sent = 0;
	logic [CHAR_W-1:0] intro [25];

	assembly_token_scanner_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.token_start(token_start),
		.token_length(token_length),
		.bad_char(bad_char),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// watch both channels for transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) ledger.take_char(ch);
			if (out_valid && out_ready)
				ledger.match_token(token_kind, token_start, token_length, bad_char, last_of_run);
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [CHAR_W-1:0] rand_letter();
		return CHAR_W'(($urandom_range(1) ? "A" : "a") + $urandom_range(25));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CHAR_W'("0" + $urandom_range(9));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_word();
		int k;
		k = $urandom_range(9);
		if (k == 0) return CH_UNDERSCORE;
		if (k < 4) return rand_digit();
		return rand_letter();
	endfunction

	function automatic logic [CHAR_W-1:0] rand_blank();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : CHAR_W'(9 + k);
	endfunction

	// offer one character, with a random gap first, until it transfers
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// one text line of mostly well-formed tokens, usually closed by a NUL
	task automatic send_line();
		int sel;
		int n;
		logic [CHAR_W-1:0] c;
		repeat ($urandom_range(1, 6)) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				// identifier, sometimes a label
				send_char($urandom_range(4) == 0 ? CH_UNDERSCORE : rand_letter());
				n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(7);
				repeat (n) send_char(rand_word());
				if ($urandom_range(2) == 0) send_char(CH_COLON);
			end else if (sel < 50) begin
				repeat ($urandom_range(1, 6)) send_char(rand_digit());
			end else if (sel < 70) begin
				// character literal, plain or escaped
				send_char(CH_QUOTE);
				if ($urandom_range(2) == 0) begin
					send_char(CH_BACKSLASH);
					send_char(CHAR_W'($urandom_range(1, 255)));
				end else begin
					do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_BACKSLASH);
					send_char(c);
				end
				send_char(CH_QUOTE);
			end else if (sel < 78) begin
				// literal cut short or left open
				send_char(CH_QUOTE);
				repeat ($urandom_range(2)) send_char(CHAR_W'($urandom_range(255)));
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 4)) send_char(rand_blank());
			end else begin
				send_char(CHAR_W'($urandom_range(255)));
			end
			if ($urandom_range(9) < 6) send_char(rand_blank());
		end
		if ($urandom_range(9) != 0) send_char(CH_NUL);
	endtask

	initial begin
		int phase;
		int base;
		ledger = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		intro = '{CH_NUL,
			"_", "9", CH_COLON,
			"z", CH_QUOTE,
			CH_QUOTE, CH_QUOTE,
			CH_QUOTE, CH_BACKSLASH, 8'hFF, CH_QUOTE,
			"0", "9", "A",
			8'h0B,
			CH_QUOTE, "a", "b", CH_NUL,
			CH_QUOTE, CH_NUL,
			"9", 8'h80, CH_NUL};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed corners
		foreach (intro[i]) send_char(intro[i]);

		// random text under each idling mix
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 63; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 63; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			base = sent;
			while (sent - base < RANDOM_PER_PHASE) send_line();
			// receiver holds off while characters keep coming
			if (phase == 0) begin
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) send_line();
			end
		end
		in_valid <= 1'b0;

		while (ledger.tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.faults == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end

endmodule
